// ----- src/ppc_pkg.sv -----
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared widths, codes and types for the playback position cursor: command
// word passed from the front end to the back end, register block, op codes.
// ----------------------------------------------------------------------------
package ppc_pkg;

  // field widths
  localparam int TIME_BITS          = 32;
  localparam int RATE_W             = 16;
  localparam int RATE_FRAC          = 8;
  localparam int MODE_W             = 2;
  localparam int LIMIT_W            = 6;
  localparam int MAX_INTERVAL_LIMIT = 32;
  localparam int OP_W               = 3;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = TIME_BITS;

  // advance = delta * rate, scaled back to Q16.16
  localparam int PROD_W = TIME_BITS + RATE_W;
  localparam int ADV_W  = PROD_W - RATE_FRAC;

  // command queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // op codes
  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PLAY  = 3'd1;
  localparam logic [OP_W-1:0] OP_PAUSE = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
  localparam logic [OP_W-1:0] OP_SEEK  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DURATION      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVALS = 2'd3;

  // loop modes (anything else is ping-pong)
  localparam logic [MODE_W-1:0] MODE_ONCE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRAP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOUNCE = 2'd2;
  // spare code, runs as ping-pong
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  // register reset values
  localparam logic [TIME_BITS-1:0] DURATION_RST      = 32'd65536;
  localparam logic [RATE_W-1:0]    RATE_RST          = 16'd256;
  localparam logic [MODE_W-1:0]    LOOP_MODE_RST     = MODE_ONCE;
  localparam logic [LIMIT_W-1:0]   MAX_INTERVALS_RST = 6'd8;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_PLAY,
    CMD_PAUSE,
    CMD_STOP,
    CMD_SEEK,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [ADV_W-1:0]     advance;
    logic [TIME_BITS-1:0] seek;
  } cmd_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] duration;
    logic [RATE_W-1:0]    rate;
    logic [MODE_W-1:0]    play_mode;
    logic [LIMIT_W-1:0]   span_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_STATUS
  } back_state_t;

endpackage

// ----- src/ppc_front.sv -----
// ----------------------------------------------------------------------------
// ppc_front
// Input side: takes words, decodes the op into a command kind, scales the
// tick time by the rate and hands command words to the queue.
// ----------------------------------------------------------------------------
module ppc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ppc_pkg::OP_W-1:0]        op,
  input  logic [ppc_pkg::TIME_BITS-1:0]   elapsed_time,
  input  logic [ppc_pkg::TIME_BITS-1:0]   seek_time,
  input  logic [ppc_pkg::RATE_W-1:0]      rate,
  output logic                            push,
  output ppc_pkg::cmd_t                   push_data,
  input  logic                            full
);

  logic                          s_valid;
  logic [ppc_pkg::OP_W-1:0]      s_op;
  logic [ppc_pkg::TIME_BITS-1:0] s_delta;
  logic [ppc_pkg::TIME_BITS-1:0] s_seek;
  logic                          p_valid;
  ppc_pkg::cmd_t                 p_cmd;
  logic                          p_take;
  ppc_pkg::cmd_kind_t            kind;
  logic [ppc_pkg::PROD_W-1:0]    product;

  // stage handshake
  assign p_take    = !p_valid || !full;
  assign in_ready  = !s_valid || p_take;
  assign push      = p_valid && !full;
  assign push_data = p_cmd;

  // op decode
  always_comb begin
    unique case (s_op)
      ppc_pkg::OP_TICK:  kind = ppc_pkg::CMD_TICK;
      ppc_pkg::OP_PLAY:  kind = ppc_pkg::CMD_PLAY;
      ppc_pkg::OP_PAUSE: kind = ppc_pkg::CMD_PAUSE;
      ppc_pkg::OP_STOP:  kind = ppc_pkg::CMD_STOP;
      ppc_pkg::OP_SEEK:  kind = ppc_pkg::CMD_SEEK;
      default:           kind = ppc_pkg::CMD_NOP;
    endcase
  end

  // advance in Q16.16, exact product truncated
  assign product = ppc_pkg::PROD_W'(s_delta) * ppc_pkg::PROD_W'(rate);

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s_valid <= in_valid;
      end
      if (p_take) begin
        p_valid <= s_valid;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_op    <= op;
      s_delta <= elapsed_time;
      s_seek  <= seek_time;
    end
    if (s_valid && p_take) begin
      p_cmd.kind    <= kind;
      p_cmd.advance <= product[ppc_pkg::PROD_W-1:ppc_pkg::RATE_FRAC];
      p_cmd.seek    <= s_seek;
    end
  end

endmodule

// ----- src/ppc_queue.sv -----
// ----------------------------------------------------------------------------
// ppc_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ppc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ppc_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output ppc_pkg::cmd_t pop_data,
  output logic          empty
);

  ppc_pkg::cmd_t               entries [ppc_pkg::QDEPTH];
  logic [ppc_pkg::QPTR_W-1:0]  wr_ptr;
  logic [ppc_pkg::QPTR_W-1:0]  rd_ptr;
  logic [ppc_pkg::QPTR_W:0]    count;

  assign full     = (count == (ppc_pkg::QPTR_W + 1)'(ppc_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ppc_pkg::QPTR_W'(ppc_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ppc_pkg::QPTR_W'(ppc_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- src/ppc_back.sv -----
// ----------------------------------------------------------------------------
// ppc_back
// Cursor engine: holds position and run flags, carries out commands, walks a tick
// one interval iteration per cycle unless the output stalls; drives result words.
// ----------------------------------------------------------------------------
module ppc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ppc_pkg::cfg_t                 cfg,
  input  logic                          empty,
  input  ppc_pkg::cmd_t                 pop_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          has_interval,
  output logic [ppc_pkg::TIME_BITS-1:0] from_time,
  output logic [ppc_pkg::TIME_BITS-1:0] to_time,
  output logic                          forward,
  output logic                          active,
  output logic                          ok,
  output logic                          last
);

  localparam int TB = ppc_pkg::TIME_BITS;
  localparam int AW = ppc_pkg::ADV_W;

  ppc_pkg::back_state_t state, state_next;

  logic [TB-1:0]              position, position_next;
  logic                       playing, playing_next;
  logic                       finished, finished_next;
  logic                       reversing, reversing_next;
  logic [AW-1:0]              remaining_advance, remaining_advance_next;
  logic [ppc_pkg::LIMIT_W-1:0] iter_count, iter_count_next;
  logic                       st_active, st_active_next;
  logic                       st_ok, st_ok_next;

  logic          slot_free;
  logic          step_en;
  logic          status_en;
  logic          tick_go;
  logic          iter_done;
  logic          out_load;
  logic          item_interval;
  logic [TB-1:0] item_from;
  logic [TB-1:0] item_to;
  logic          item_forward;
  logic          item_active;
  logic          item_ok;
  logic          item_last;

  // iteration datapath
  logic [TB-1:0]               dur;
  logic [ppc_pkg::LIMIT_W-1:0] lim;
  logic                        is_once;
  logic                        is_wrap;
  logic                        going_back;
  logic [AW:0]                 once_sum;
  logic                        once_hit;
  logic [TB-1:0]               once_next;
  logic [TB-1:0]               it_from;
  logic [TB-1:0]               span_left;
  logic [TB-1:0]               step;
  logic [TB-1:0]               it_to;
  logic [AW-1:0]               rem_after;
  logic                        bounce;
  logic                        limit_hit;

  assign slot_free = !out_valid || out_ready;
  assign dur       = cfg.duration;
  assign lim       = (cfg.span_limit > ppc_pkg::LIMIT_W'(ppc_pkg::MAX_INTERVAL_LIMIT))
                   ? ppc_pkg::LIMIT_W'(ppc_pkg::MAX_INTERVAL_LIMIT) : cfg.span_limit;
  assign is_once    = (cfg.play_mode == ppc_pkg::MODE_ONCE);
  assign is_wrap    = (cfg.play_mode == ppc_pkg::MODE_WRAP);
  assign going_back = !is_wrap && reversing;
  assign limit_hit  = (iter_count >= lim);

  // once mode: clamp the whole advance at the clip end
  assign once_sum  = (AW + 1)'(position) + (AW + 1)'(remaining_advance);
  assign once_hit  = (once_sum >= (AW + 1)'(dur));
  assign once_next = once_hit ? dur : once_sum[TB-1:0];

  // loop and ping-pong: one leg toward the next end
  always_comb begin
    if (is_wrap) begin
      it_from   = (position >= dur) ? '0 : position;
      span_left = dur - it_from;
    end else begin
      it_from = position;
      if (reversing) begin
        span_left = position;
      end else begin
        span_left = (dur > position) ? dur - position : '0;
      end
    end
  end

  assign step      = (remaining_advance < AW'(span_left)) ? remaining_advance[TB-1:0]
                                                          : span_left;
  assign it_to     = going_back ? it_from - step : it_from + step;
  assign rem_after = remaining_advance - AW'(step);
  assign bounce    = (!reversing && it_to >= dur) || (reversing && it_to == '0);

  // sequencer controls
  always_comb begin
    pop       = (state == ppc_pkg::ST_IDLE) && !empty;
    step_en   = (state == ppc_pkg::ST_ITER) && slot_free;
    status_en = (state == ppc_pkg::ST_STATUS) && slot_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ppc_pkg::ST_IDLE: begin
        if (!empty) begin
          state_next = tick_go ? ppc_pkg::ST_ITER : ppc_pkg::ST_STATUS;
        end
      end
      ppc_pkg::ST_ITER: begin
        if (step_en && iter_done) begin
          state_next = ppc_pkg::ST_STATUS;
        end
      end
      ppc_pkg::ST_STATUS: begin
        if (slot_free) begin
          state_next = ppc_pkg::ST_IDLE;
        end
      end
      default: state_next = ppc_pkg::ST_IDLE;
    endcase
  end

  // command execution and result words
  always_comb begin
    position_next          = position;
    playing_next           = playing;
    finished_next          = finished;
    reversing_next         = reversing;
    remaining_advance_next = remaining_advance;
    iter_count_next        = iter_count;
    st_active_next         = st_active;
    st_ok_next             = st_ok;
    tick_go                = 1'b0;
    iter_done              = 1'b0;
    out_load               = 1'b0;
    item_interval          = 1'b0;
    item_from              = '0;
    item_to                = '0;
    item_forward           = 1'b0;
    item_active            = 1'b0;
    item_ok                = 1'b0;
    item_last              = 1'b0;

    if (pop) begin
      st_ok_next = 1'b1;
      unique case (pop_data.kind)
        ppc_pkg::CMD_TICK: begin
          if (!playing || finished) begin
            st_active_next = 1'b0;
          end else if (dur == '0 || cfg.span_limit == '0) begin
            playing_next   = 1'b0;
            finished_next  = 1'b1;
            position_next  = '0;
            reversing_next = 1'b0;
            st_active_next = 1'b0;
            st_ok_next     = 1'b0;
          end else begin
            remaining_advance_next = pop_data.advance;
            iter_count_next        = '0;
            st_active_next         = 1'b1;
            tick_go                = (pop_data.advance != '0);
          end
        end
        ppc_pkg::CMD_PLAY: begin
          playing_next   = 1'b1;
          finished_next  = 1'b0;
          st_active_next = 1'b1;
        end
        ppc_pkg::CMD_PAUSE: begin
          playing_next   = 1'b0;
          st_active_next = 1'b0;
        end
        ppc_pkg::CMD_STOP: begin
          playing_next   = 1'b0;
          finished_next  = 1'b1;
          position_next  = '0;
          reversing_next = 1'b0;
          st_active_next = 1'b0;
        end
        ppc_pkg::CMD_SEEK: begin
          position_next  = (pop_data.seek < dur) ? pop_data.seek : dur;
          st_active_next = playing && !finished;
        end
        default: begin
          st_active_next = playing && !finished;
        end
      endcase
    end

    if (step_en) begin
      if (is_once) begin
        // single clamped move; stop if it reaches the end
        if (once_next != position) begin
          out_load      = 1'b1;
          item_interval = 1'b1;
          item_from     = position;
          item_to       = once_next;
          item_forward  = 1'b1;
        end
        position_next          = once_next;
        remaining_advance_next = '0;
        if (once_hit) begin
          playing_next  = 1'b0;
          finished_next = 1'b1;
        end
        st_active_next = !once_hit;
        st_ok_next     = 1'b1;
        iter_done      = 1'b1;
      end else if (limit_hit) begin
        // out of iterations: stop where we are
        playing_next   = 1'b0;
        finished_next  = 1'b1;
        st_active_next = 1'b0;
        st_ok_next     = 1'b0;
        iter_done      = 1'b1;
      end else begin
        iter_count_next = iter_count + 1'b1;
        if (step != '0) begin
          out_load      = 1'b1;
          item_interval = 1'b1;
          item_from     = it_from;
          item_to       = it_to;
          item_forward  = !going_back;
        end
        if (is_wrap) begin
          position_next = (it_to >= dur) ? '0 : it_to;
        end else if (bounce) begin
          position_next  = reversing ? '0 : dur;
          reversing_next = !reversing;
        end else begin
          position_next = it_to;
        end
        remaining_advance_next = rem_after;
        if (rem_after == '0) begin
          st_active_next = 1'b1;
          st_ok_next     = 1'b1;
          iter_done      = 1'b1;
        end
      end
    end

    if (status_en) begin
      out_load    = 1'b1;
      item_active = st_active;
      item_ok     = st_ok;
      item_last   = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ppc_pkg::ST_IDLE;
      position          <= '0;
      playing           <= 1'b0;
      finished          <= 1'b0;
      reversing         <= 1'b0;
      remaining_advance <= '0;
      iter_count        <= '0;
      out_valid         <= 1'b0;
    end else begin
      state             <= state_next;
      position          <= position_next;
      playing           <= playing_next;
      finished          <= finished_next;
      reversing         <= reversing_next;
      remaining_advance <= remaining_advance_next;
      iter_count        <= iter_count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // status flags and output word
  always_ff @(posedge clk) begin
    st_active <= st_active_next;
    st_ok     <= st_ok_next;
    if (out_load) begin
      has_interval <= item_interval;
      from_time    <= item_from;
      to_time      <= item_to;
      forward      <= item_forward;
      active       <= item_active;
      ok           <= item_ok;
      last         <= item_last;
    end
  end

  // an interval word always covers some distance
  a_no_empty_interval: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_interval |-> from_time != to_time)
    else $error("empty interval emitted");

  // iterations never run past the hard limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == ppc_pkg::ST_ITER |-> iter_count <= ppc_pkg::LIMIT_W'(ppc_pkg::MAX_INTERVAL_LIMIT))
    else $error("interval count beyond limit");

  // a tick that starts iterating begins with a clear count
  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    pop && tick_go |=> iter_count == '0 && state == ppc_pkg::ST_ITER)
    else $error("tick started with stale count");

endmodule

// ----- src/playback_position_cursor.sv -----
// ----------------------------------------------------------------------------
// playback_position_cursor
// Q16.16 playback cursor with play, pause, stop, seek and tick commands.
// ----------------------------------------------------------------------------
// Input words (op, elapsed_time, seek_time) enter on in_valid/in_ready. Every
// word yields zero or more interval words (has_interval = 1) followed by one
// status word with last = 1, all on out_valid/out_ready.
// The user writes configuration registers through cfg_we/cfg_index/cfg_data only
// while the block is idle (the block itself does not enforce it); they take effect on the next word.
// The front end registers each accepted word in its decode and scale stages and
// pushes it to the command queue, from which the back end pops it; each result
// word is registered. A tick in loop or ping-pong mode spends one cycle per
// interval iteration while the output slot is free, up to the interval limit
// (at most 32) plus one over-limit check; in once mode a tick makes one clamped
// move. The back end pops a new word only once the last status word is loaded.
// The back end handles one word at a time; a two-entry command queue and the
// front pipeline keep accepting words while it works.
// Reset clears the position and run flags and restores the register defaults
// (duration 1.0, rate 1.0, once mode, eight intervals).
// When out_ready is low the result word is held and the back end waits; the
// queue then fills and in_ready drops.
// ----------------------------------------------------------------------------
module playback_position_cursor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ppc_pkg::OP_W-1:0]         op,
  input  logic [ppc_pkg::TIME_BITS-1:0]    elapsed_time,
  input  logic [ppc_pkg::TIME_BITS-1:0]    seek_time,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             has_interval,
  output logic [ppc_pkg::TIME_BITS-1:0]    from_time,
  output logic [ppc_pkg::TIME_BITS-1:0]    to_time,
  output logic                             forward,
  output logic                             active,
  output logic                             ok,
  output logic                             last
);

  ppc_pkg::cfg_t cfg;
  logic          push;
  ppc_pkg::cmd_t push_data;
  logic          full;
  logic          pop;
  ppc_pkg::cmd_t pop_data;
  logic          empty;

  // register block
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duration   <= ppc_pkg::DURATION_RST;
      cfg.rate       <= ppc_pkg::RATE_RST;
      cfg.play_mode  <= ppc_pkg::LOOP_MODE_RST;
      cfg.span_limit <= ppc_pkg::MAX_INTERVALS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ppc_pkg::REG_DURATION:      cfg.duration   <= cfg_data[ppc_pkg::TIME_BITS-1:0];
        ppc_pkg::REG_RATE:          cfg.rate       <= cfg_data[ppc_pkg::RATE_W-1:0];
        ppc_pkg::REG_LOOP_MODE:     cfg.play_mode  <= cfg_data[ppc_pkg::MODE_W-1:0];
        ppc_pkg::REG_MAX_INTERVALS: cfg.span_limit <= cfg_data[ppc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // decode and scale
  ppc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .elapsed_time (elapsed_time),
    .seek_time    (seek_time),
    .rate         (cfg.rate),
    .push         (push),
    .push_data    (push_data),
    .full         (full)
  );

  // command queue
  ppc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // cursor engine
  ppc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .empty        (empty),
    .pop_data     (pop_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .has_interval (has_interval),
    .from_time    (from_time),
    .to_time      (to_time),
    .forward      (forward),
    .active       (active),
    .ok           (ok),
    .last         (last)
  );

endmodule
